/* design/q4es_pkg.sv */
// Shared types, constants and arithmetic helpers for the quad4 element stiffness unit.
`default_nettype none

package q4es_pkg;

    localparam int unsigned NumCoords = 8;
    localparam int unsigned NumDregs  = 6;
    localparam int unsigned DivBits   = 80;

    // Shape function derivative magnitudes, signed Q1.16: (1-g)/4 and (1+g)/4.
    localparam logic signed [16:0] DnLo = 17'sd6925;
    localparam logic signed [16:0] DnHi = 17'sd25843;

    localparam logic signed [63:0] SatMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SatMin = 64'sh8000_0000_0000_0000;

    typedef logic [NumCoords-1:0][31:0] t_coords;
    typedef logic [NumDregs-1:0][31:0]  t_dregs;

    typedef struct packed {
        logic    valid;
        t_coords coords;
    } t_qhead;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_16,
        SH_32
    } t_shift;

    typedef enum logic [2:0] {
        CFG_D_XX_XX,
        CFG_D_XX_YY,
        CFG_D_XX_XY,
        CFG_D_YY_YY,
        CFG_D_YY_XY,
        CFG_D_XY_XY,
        CFG_GAUSS_WEIGHT
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JAC,
        ST_DET_A,
        ST_DET_B,
        ST_VOL,
        ST_NUM_A,
        ST_NUM_B,
        ST_DIV,
        ST_DB,
        ST_KB,
        ST_KV,
        ST_OUT_RD,
        ST_OUT_WR
    } t_bstate;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sadd = a[63] ? SatMin : SatMax;
        end else begin
            sadd = s;
        end
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            ssub = a[63] ? SatMin : SatMax;
        end else begin
            ssub = s;
        end
    endfunction

    // Derivative of shape function i along xi (j = 0) or eta (j = 1) at Gauss point (gi, gj).
    function automatic logic signed [16:0] dn(input logic j, input logic [1:0] i,
                                              input logic gi, input logic gj);
        logic signed [16:0] p, q, r, s, v;
        p = gj ? DnLo : DnHi;
        q = gj ? DnHi : DnLo;
        r = gi ? DnLo : DnHi;
        s = gi ? DnHi : DnLo;
        if (!j) begin
            unique case (i)
                2'd0: v = -p;
                2'd1: v = p;
                2'd2: v = q;
                2'd3: v = -q;
            endcase
        end else begin
            unique case (i)
                2'd0: v = -r;
                2'd1: v = -s;
                2'd2: v = s;
                2'd3: v = r;
            endcase
        end
        dn = v;
    endfunction

    // Register holding entry (k, m) of the symmetric constitutive matrix.
    function automatic logic [2:0] d_index(input logic [1:0] k, input logic [1:0] m);
        logic [2:0] v;
        unique case ({k, m})
            4'b0000: v = 3'd0;
            4'b0001: v = 3'd1;
            4'b0010: v = 3'd2;
            4'b0100: v = 3'd1;
            4'b0101: v = 3'd3;
            4'b0110: v = 3'd4;
            4'b1000: v = 3'd2;
            4'b1001: v = 3'd4;
            default: v = 3'd5;
        endcase
        d_index = v;
    endfunction

endpackage

`default_nettype wire

/* design/q4es_front.sv */
// Input side: accepts element words into a short queue ahead of the compute engine.
`default_nettype none

module q4es_front #(
    parameter int QDEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire q4es_pkg::t_coords i_coords,
    output q4es_pkg::t_qhead       o_head,
    input  wire logic              i_pop
);

    localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CntW = $clog2(QDEPTH + 1);

    q4es_pkg::t_coords r_q [QDEPTH];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              push;

    assign o_ready = (r_cnt != CntW'(QDEPTH));
    assign push    = i_valid && o_ready;
    assign o_head  = {(r_cnt != '0), r_q[r_rd]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(push) - CntW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_coords;
        end
    end

endmodule

`default_nettype wire

/* design/q4es_mul.sv */
// Shared 64x64 signed multiplier built from one 32x32 unit, with rounding shift and saturation.
`default_nettype none

module q4es_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    input  wire q4es_pkg::t_shift   i_sh,
    output logic                    o_done,
    output logic signed [63:0]      o_res
);

    logic [63:0]        r_am;
    logic [63:0]        r_bm;
    logic               r_neg;
    q4es_pkg::t_shift   r_sh;
    logic [2:0]         r_step;
    logic               r_busy;
    logic [63:0]        r_pp;
    logic [1:0]         r_off;
    logic [127:0]       r_acc;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [31:0]        a_part;
    logic [31:0]        b_part;
    logic [127:0]       pp_sh;
    logic [127:0]       half;
    logic [127:0]       sum;
    logic [127:0]       shifted;
    logic signed [63:0] sat;

    assign a_part = r_step[1] ? r_am[63:32] : r_am[31:0];
    assign b_part = r_step[0] ? r_bm[63:32] : r_bm[31:0];

    always_comb begin
        unique case (r_off)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd1:    pp_sh = {32'd0, r_pp, 32'd0};
            default: pp_sh = {r_pp, 64'd0};
        endcase
    end

    // Round half away from zero on the magnitude, then clamp to the signed range.
    always_comb begin
        unique case (r_sh)
            q4es_pkg::SH_16: half = 128'h8000;
            q4es_pkg::SH_32: half = 128'h8000_0000;
            default:         half = '0;
        endcase
        sum = r_acc + half;
        unique case (r_sh)
            q4es_pkg::SH_16: shifted = sum >> 16;
            q4es_pkg::SH_32: shifted = sum >> 32;
            default:         shifted = sum;
        endcase
        if (|shifted[127:63]) begin
            sat = r_neg ? q4es_pkg::SatMin : q4es_pkg::SatMax;
        end else begin
            sat = r_neg ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_am  <= q4es_pkg::mag(i_a);
            r_bm  <= q4es_pkg::mag(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_sh;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step <= 3'd3) begin
                r_pp  <= a_part * b_part;
                r_off <= 2'(r_step[1]) + 2'(r_step[0]);
            end
            if (r_step != 3'd0 && r_step <= 3'd4) begin
                r_acc <= r_acc + pp_sh;
            end
            if (r_step == 3'd5) begin
                r_res <= sat;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

/* design/q4es_div.sv */
// Bit-serial divider: round(n * 2^16 / d) with saturation, zero when d is zero.
`default_nettype none

module q4es_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_n,
    input  wire logic signed [63:0] i_d,
    output logic                    o_done,
    output logic signed [63:0]      o_q
);

    localparam int DivW = q4es_pkg::DivBits;

    logic                 r_busy;
    logic                 r_fin;
    logic                 r_done;
    logic [6:0]           r_cnt;
    logic [63:0]          r_dm;
    logic [DivW-1:0]      r_num;
    logic [63:0]          r_rem;
    logic [DivW-1:0]      r_q;
    logic                 r_neg;
    logic signed [63:0]   r_res;

    logic [63:0]          nm;
    logic [63:0]          dm;
    logic [64:0]          rem_n;
    logic                 ge;
    logic [64:0]          rem_sub;
    logic signed [63:0]   sat;

    assign nm      = q4es_pkg::mag(i_n);
    assign dm      = q4es_pkg::mag(i_d);
    assign rem_n   = {r_rem, r_num[DivW-1]};
    assign ge      = (rem_n >= {1'b0, r_dm});
    assign rem_sub = rem_n - {1'b0, r_dm};

    always_comb begin
        if (|r_q[DivW-1:63]) begin
            sat = r_neg ? q4es_pkg::SatMin : q4es_pkg::SatMax;
        end else begin
            sat = r_neg ? -$signed(r_q[63:0]) : $signed(r_q[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                if (i_d == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 7'(DivW);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dm  <= dm;
            // Dividend is |n| * 2^16 plus half the divisor, for round to nearest.
            r_num <= ({16'd0, nm} << 16) + {17'd0, dm[63:1]};
            r_rem <= '0;
            r_q   <= '0;
            r_neg <= i_n[63] ^ i_d[63];
            r_res <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? rem_sub[63:0] : rem_n[63:0];
            r_q   <= {r_q[DivW-2:0], ge};
        end else if (r_fin) begin
            r_res <= sat;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

`default_nettype wire

/* design/q4es_back.sv */
// Compute engine: Gauss point loop, stiffness accumulation in memory, and the result word stream.
`default_nettype none

module q4es_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire q4es_pkg::t_qhead  i_head,
    output logic                   o_pop,
    input  wire q4es_pkg::t_dregs  i_d,
    input  wire logic [31:0]       i_w,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_row_index,
    output logic [2:0]             o_col_index,
    output logic signed [63:0]     o_stiffness_value,
    output logic                   o_bad_jacobian,
    output logic                   o_last_entry
);

    q4es_pkg::t_bstate  r_state;
    q4es_pkg::t_bstate  n_state;

    q4es_pkg::t_coords  r_x;
    logic [1:0]         r_g;
    logic [1:0]         r_e;
    logic [2:0]         r_i;
    logic [2:0]         r_j;
    logic [1:0]         r_k;
    logic [1:0]         r_m;
    logic               r_r;
    logic               r_wait;
    logic               r_bad;

    logic signed [63:0] r_jac [4];
    logic signed [63:0] r_det;
    logic signed [63:0] r_vol;
    logic signed [63:0] r_tmp;
    logic signed [63:0] r_c [8];
    logic signed [63:0] r_db [24];
    logic signed [63:0] r_kmem [64];
    logic signed [63:0] r_krd;

    logic               r_ovalid;
    logic [2:0]         r_orow;
    logic [2:0]         r_ocol;
    logic signed [63:0] r_oval;
    logic               r_obad;
    logic               r_olast;

    logic               mul_start;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    q4es_pkg::t_shift   mul_sh;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic               div_start;
    logic               div_done;
    logic signed [63:0] div_q;

    logic [1:0]         b_m;
    logic [2:0]         b_j;
    logic [2:0]         b_sel;
    logic               b_zero;
    logic signed [63:0] b_val;
    logic [1:0]         i2;
    logic               out_load;
    logic               k_we;
    logic [5:0]         k_addr;
    logic signed [63:0] k_wdata;
    logic signed [63:0] db_sum;
    logic signed [63:0] t_sum;

    assign i2       = r_i[1:0];
    assign k_addr   = {r_i, r_j};
    assign out_load = (r_state == q4es_pkg::ST_OUT_WR) && (!r_ovalid || i_ready);
    assign db_sum   = q4es_pkg::sadd(r_tmp, mul_res);
    assign t_sum    = q4es_pkg::sadd(r_tmp, mul_res);

    // Strain matrix entry B[b_m][b_j]: a Cartesian derivative or zero.
    always_comb begin
        unique case (b_m)
            2'd0: begin
                b_zero = b_j[0];
                b_sel  = {1'b0, b_j[2:1]};
            end
            2'd1: begin
                b_zero = !b_j[0];
                b_sel  = {1'b1, b_j[2:1]};
            end
            default: begin
                b_zero = 1'b0;
                b_sel  = {!b_j[0], b_j[2:1]};
            end
        endcase
        b_val = b_zero ? '0 : r_c[b_sel];
    end

    q4es_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_sh    (mul_sh),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    q4es_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (r_tmp),
        .i_d     (r_det),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            q4es_pkg::ST_IDLE: begin
                if (i_head.valid) n_state = q4es_pkg::ST_JAC;
            end
            q4es_pkg::ST_JAC: begin
                if (mul_done && i2 == 2'd3 && r_e == 2'd3) n_state = q4es_pkg::ST_DET_A;
            end
            q4es_pkg::ST_DET_A: begin
                if (mul_done) n_state = q4es_pkg::ST_DET_B;
            end
            q4es_pkg::ST_DET_B: begin
                if (mul_done) n_state = q4es_pkg::ST_VOL;
            end
            q4es_pkg::ST_VOL: begin
                if (mul_done) n_state = q4es_pkg::ST_NUM_A;
            end
            q4es_pkg::ST_NUM_A: begin
                if (mul_done) n_state = q4es_pkg::ST_NUM_B;
            end
            q4es_pkg::ST_NUM_B: begin
                if (mul_done) n_state = q4es_pkg::ST_DIV;
            end
            q4es_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = (r_r && i2 == 2'd3) ? q4es_pkg::ST_DB : q4es_pkg::ST_NUM_A;
                end
            end
            q4es_pkg::ST_DB: begin
                if (mul_done && r_m == 2'd2 && r_k == 2'd2 && r_j == 3'd7) begin
                    n_state = q4es_pkg::ST_KB;
                end
            end
            q4es_pkg::ST_KB: begin
                if (mul_done && r_k == 2'd2) n_state = q4es_pkg::ST_KV;
            end
            q4es_pkg::ST_KV: begin
                if (mul_done) begin
                    if (k_addr != 6'd63) begin
                        n_state = q4es_pkg::ST_KB;
                    end else if (r_g == 2'd3) begin
                        n_state = q4es_pkg::ST_OUT_RD;
                    end else begin
                        n_state = q4es_pkg::ST_JAC;
                    end
                end
            end
            q4es_pkg::ST_OUT_RD: n_state = q4es_pkg::ST_OUT_WR;
            q4es_pkg::ST_OUT_WR: begin
                if (out_load) begin
                    n_state = (k_addr == 6'd63) ? q4es_pkg::ST_IDLE : q4es_pkg::ST_OUT_RD;
                end
            end
            default: n_state = q4es_pkg::ST_IDLE;
        endcase
    end

    // Operand selection and unit control.
    always_comb begin
        o_pop     = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_sh    = q4es_pkg::SH_NONE;
        b_m       = '0;
        b_j       = '0;
        k_we      = 1'b0;
        k_wdata   = q4es_pkg::sadd((r_g == 2'd0) ? 64'sd0 : r_krd, mul_res);
        unique case (r_state)
            q4es_pkg::ST_IDLE: o_pop = i_head.valid;
            q4es_pkg::ST_JAC: begin
                mul_start = !r_wait;
                mul_a = 64'(q4es_pkg::dn(r_e[1], i2, r_g[1], r_g[0]));
                mul_b = 64'($signed(r_x[{i2, r_e[0]}]));
            end
            q4es_pkg::ST_DET_A: begin
                mul_start = !r_wait;
                mul_a  = r_jac[0];
                mul_b  = r_jac[3];
                mul_sh = q4es_pkg::SH_32;
            end
            q4es_pkg::ST_DET_B: begin
                mul_start = !r_wait;
                mul_a  = r_jac[1];
                mul_b  = r_jac[2];
                mul_sh = q4es_pkg::SH_32;
            end
            q4es_pkg::ST_VOL: begin
                mul_start = !r_wait;
                mul_a  = r_det;
                mul_b  = {32'd0, i_w};
                mul_sh = q4es_pkg::SH_16;
            end
            q4es_pkg::ST_NUM_A: begin
                mul_start = !r_wait;
                mul_a = r_r ? r_jac[0] : r_jac[3];
                mul_b = 64'(q4es_pkg::dn(r_r, i2, r_g[1], r_g[0]));
            end
            q4es_pkg::ST_NUM_B: begin
                mul_start = !r_wait;
                mul_a = r_r ? r_jac[2] : r_jac[1];
                mul_b = 64'(q4es_pkg::dn(!r_r, i2, r_g[1], r_g[0]));
            end
            q4es_pkg::ST_DIV: div_start = !r_wait;
            q4es_pkg::ST_DB: begin
                mul_start = !r_wait;
                b_m    = r_m;
                b_j    = r_j;
                mul_a  = 64'($signed(i_d[q4es_pkg::d_index(r_k, r_m)]));
                mul_b  = b_val;
                mul_sh = q4es_pkg::SH_16;
            end
            q4es_pkg::ST_KB: begin
                mul_start = !r_wait;
                b_m    = r_k;
                b_j    = r_i;
                mul_a  = b_val;
                mul_b  = r_db[{r_k, r_j}];
                mul_sh = q4es_pkg::SH_32;
            end
            q4es_pkg::ST_KV: begin
                mul_start = !r_wait;
                mul_a  = r_tmp;
                mul_b  = r_vol;
                mul_sh = q4es_pkg::SH_32;
                k_we   = mul_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= q4es_pkg::ST_IDLE;
            r_g      <= '0;
            r_e      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_m      <= '0;
            r_r      <= 1'b0;
            r_wait   <= 1'b0;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mul_start || div_start) begin
                r_wait <= 1'b1;
            end else if (mul_done || div_done) begin
                r_wait <= 1'b0;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                q4es_pkg::ST_IDLE: begin
                    if (i_head.valid) r_bad <= 1'b0;
                end
                q4es_pkg::ST_JAC: begin
                    if (mul_done) begin
                        r_i <= {1'b0, i2 + 2'd1};
                        if (i2 == 2'd3) r_e <= r_e + 2'd1;
                    end
                end
                q4es_pkg::ST_VOL: begin
                    if (mul_done && (mul_res[63] || mul_res == '0)) r_bad <= 1'b1;
                end
                q4es_pkg::ST_DIV: begin
                    if (div_done) begin
                        r_r <= !r_r;
                        if (r_r) r_i <= {1'b0, i2 + 2'd1};
                    end
                end
                q4es_pkg::ST_DB: begin
                    if (mul_done) begin
                        if (r_m == 2'd2) begin
                            r_m <= '0;
                            r_j <= r_j + 3'd1;
                            if (r_j == 3'd7) r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                        end else begin
                            r_m <= r_m + 2'd1;
                        end
                    end
                end
                q4es_pkg::ST_KB: begin
                    if (mul_done) r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
                q4es_pkg::ST_KV: begin
                    if (mul_done) begin
                        {r_i, r_j} <= k_addr + 6'd1;
                        if (k_addr == 6'd63) r_g <= r_g + 2'd1;
                    end
                end
                q4es_pkg::ST_OUT_WR: begin
                    if (out_load) {r_i, r_j} <= k_addr + 6'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_x <= i_head.coords;
        unique case (r_state)
            q4es_pkg::ST_JAC: begin
                if (mul_done) r_jac[r_e] <= ((i2 == 2'd0) ? 64'sd0 : r_jac[r_e]) + mul_res;
            end
            q4es_pkg::ST_DET_A, q4es_pkg::ST_NUM_A: begin
                if (mul_done) r_tmp <= mul_res;
            end
            q4es_pkg::ST_DET_B: begin
                if (mul_done) r_det <= q4es_pkg::ssub(r_tmp, mul_res);
            end
            q4es_pkg::ST_VOL: begin
                if (mul_done) r_vol <= mul_res;
            end
            q4es_pkg::ST_NUM_B: begin
                if (mul_done) r_tmp <= r_tmp - mul_res;
            end
            q4es_pkg::ST_DIV: begin
                if (div_done) begin
                    r_c[{r_r, i2}] <= div_q;
                    r_tmp          <= '0;
                end
            end
            q4es_pkg::ST_DB: begin
                if (mul_done) begin
                    if (r_m == 2'd2) begin
                        r_db[{r_k, r_j}] <= db_sum;
                        r_tmp            <= '0;
                    end else begin
                        r_tmp <= db_sum;
                    end
                end
            end
            q4es_pkg::ST_KB: begin
                if (mul_done) r_tmp <= t_sum;
            end
            q4es_pkg::ST_KV: begin
                if (mul_done) r_tmp <= '0;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_orow  <= r_i;
            r_ocol  <= r_j;
            r_oval  <= r_krd;
            r_obad  <= r_bad;
            r_olast <= (k_addr == 6'd63);
        end
    end

    // Stiffness memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (k_we) r_kmem[k_addr] <= k_wdata;
        r_krd <= r_kmem[k_addr];
    end

    assign o_valid           = r_ovalid;
    assign o_row_index       = r_orow;
    assign o_col_index       = r_ocol;
    assign o_stiffness_value = r_oval;
    assign o_bad_jacobian    = r_obad;
    assign o_last_entry      = r_olast;

endmodule

`default_nettype wire

/* design/quad4_element_stiffness_unit.sv */
// The engine takes one element at a time; its pace is set by the single shared 32x32 multiplier
// (363 products per Gauss point) and the bit-serial divider (eight quotients per Gauss point);
// results leave one word at a time via a read and a write state, held while a word waits on i_ready.
// The input queue holds QDEPTH elements, so words are taken while the engine is busy, until full.
// Reset is synchronous and active low; it empties the queue and loads the register defaults.
`default_nettype none

module quad4_element_stiffness_unit #(
    parameter int QDEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_node0_x,
    input  wire logic signed [31:0] i_node0_y,
    input  wire logic signed [31:0] i_node1_x,
    input  wire logic signed [31:0] i_node1_y,
    input  wire logic signed [31:0] i_node2_x,
    input  wire logic signed [31:0] i_node2_y,
    input  wire logic signed [31:0] i_node3_x,
    input  wire logic signed [31:0] i_node3_y,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_row_index,
    output logic [2:0]              o_col_index,
    output logic signed [63:0]      o_stiffness_value,
    output logic                    o_bad_jacobian,
    output logic                    o_last_entry,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    q4es_pkg::t_dregs  r_d;
    logic [31:0]       r_w;
    q4es_pkg::t_coords coords;
    q4es_pkg::t_qhead  head;
    logic              pop;

    assign coords = {i_node3_y, i_node3_x, i_node2_y, i_node2_x,
                     i_node1_y, i_node1_x, i_node0_y, i_node0_x};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
            r_w <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (q4es_pkg::t_cfg_reg'(i_cfg_index))
                q4es_pkg::CFG_D_XX_XX:      r_d[0] <= i_cfg_data;
                q4es_pkg::CFG_D_XX_YY:      r_d[1] <= i_cfg_data;
                q4es_pkg::CFG_D_XX_XY:      r_d[2] <= i_cfg_data;
                q4es_pkg::CFG_D_YY_YY:      r_d[3] <= i_cfg_data;
                q4es_pkg::CFG_D_YY_XY:      r_d[4] <= i_cfg_data;
                q4es_pkg::CFG_D_XY_XY:      r_d[5] <= i_cfg_data;
                q4es_pkg::CFG_GAUSS_WEIGHT: r_w    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    q4es_front #(
        .QDEPTH (QDEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_coords (coords),
        .o_head   (head),
        .i_pop    (pop)
    );

    q4es_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_pop             (pop),
        .i_d               (r_d),
        .i_w               (r_w),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_row_index       (o_row_index),
        .o_col_index       (o_col_index),
        .o_stiffness_value (o_stiffness_value),
        .o_bad_jacobian    (o_bad_jacobian),
        .o_last_entry      (o_last_entry)
    );

`ifndef SYNTHESIS
    a_last_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_entry |-> o_row_index == 3'd7 && o_col_index == 3'd7)
        else $error("last word is not entry (7,7)");

    a_entries_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_entry |=> !o_valid ||
            {o_row_index, o_col_index} == $past({o_row_index, o_col_index}) + 6'd1)
        else $error("stiffness words out of order");

    a_flag_per_element: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_entry |=> !o_valid ||
            o_bad_jacobian == $past(o_bad_jacobian))
        else $error("bad Jacobian flag changed inside an element");
`endif

endmodule

`default_nettype wire
